### rtl/assert_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the colour ramp checker.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising edge, ignoring cycles in reset.
`define SBCR_ASSERT(lbl, clk_s, rstn_s, prop) \
  lbl: assert property (@(posedge clk_s) disable iff (!rstn_s) prop) \
    else $error("sbcr assertion failed");

// Check a property on every rising edge, reset cycles included.
`define SBCR_ASSERT_ALWAYS(lbl, clk_s, prop) \
  lbl: assert property (@(posedge clk_s) prop) \
    else $error("sbcr assertion failed");

`endif

### rtl/sbcr_pkg.sv
// ---------------------------------------------------------------------------
// sbcr_pkg
// Types, constants and ramp lookup helpers for the colour ramp pipeline.
// ---------------------------------------------------------------------------
package sbcr_pkg;

  localparam int RAMP_POINTS = 4;
  localparam int REG_POINTS  = 4;
  localparam int SEG_W       = $clog2(RAMP_POINTS);
  localparam int PT_IDX_W    = $clog2(REG_POINTS);
  localparam int PT_W        = 48;
  localparam int IDX_W       = 3;
  localparam int SQ_STEPS    = 32;
  localparam int DIV_STEPS   = 8;

  // register indexes on the configuration channel
  localparam logic [IDX_W-1:0] IDX_GAIN = 3'd0;
  localparam logic [IDX_W-1:0] IDX_PT0  = 3'd1;
  localparam logic [IDX_W-1:0] IDX_PT1  = 3'd2;
  localparam logic [IDX_W-1:0] IDX_PT2  = 3'd3;
  localparam logic [IDX_W-1:0] IDX_PT3  = 3'd4;

  localparam logic [15:0]     GAIN_RST = 16'hFFFF;
  localparam logic [PT_W-1:0] PT0_RST  = 48'h000000000000;
  localparam logic [PT_W-1:0] PT1_RST  = 48'h555500555555;
  localparam logic [PT_W-1:0] PT2_RST  = 48'hAAAA00AAAAAA;
  localparam logic [PT_W-1:0] PT3_RST  = 48'hFFFF00FFFFFF;
  localparam logic [15:0]     LEVEL_MAX = 16'hFFFF;

  typedef logic [PT_W-1:0] pt_arr_t [REG_POINTS];

  typedef struct packed {
    logic [63:0] v;
    logic [63:0] r;
    logic        last;
  } sq_t;

  typedef struct packed {
    logic [15:0] level;
    logic [15:0] lo;
    logic [15:0] hi;
    logic [23:0] col_lo;
    logic [23:0] col_hi;
    logic        last;
  } seg_t;

  typedef struct packed {
    logic [2:0][16:0] rem;
    logic [2:0][7:0]  q;
    logic [2:0][7:0]  nlo;
    logic             byp;
    logic [15:0]      s;
    logic [15:0]      level;
    logic             last;
  } div_t;

  // points past the register file repeat the last one
  function automatic logic [PT_W-1:0] pt_get(pt_arr_t pts, int i);
    int j;
    j = (i >= REG_POINTS) ? REG_POINTS - 1 : i;
    return pts[PT_IDX_W'(j)];
  endfunction

  function automatic logic [15:0] pt_thr(pt_arr_t pts, int i);
    logic [PT_W-1:0] p;
    p = pt_get(pts, i);
    return p[47:32];
  endfunction

  function automatic logic [23:0] pt_col(pt_arr_t pts, int i);
    logic [PT_W-1:0] p;
    p = pt_get(pts, i);
    return p[23:0];
  endfunction

endpackage

### rtl/sbcr_in_if.sv
// ---------------------------------------------------------------------------
// sbcr_in_if
// Input word channel: one complex bin per word.
// ---------------------------------------------------------------------------
interface sbcr_in_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] real_part;
  logic signed [31:0] imag_part;
  logic               last_bin;

  modport source (output valid, real_part, imag_part, last_bin, input ready);
  modport sink   (input valid, real_part, imag_part, last_bin, output ready);
endinterface

### rtl/sbcr_out_if.sv
// ---------------------------------------------------------------------------
// sbcr_out_if
// Result word channel: level and RGB colour.
// ---------------------------------------------------------------------------
interface sbcr_out_if;
  logic        valid;
  logic        ready;
  logic [15:0] level;
  logic [7:0]  red;
  logic [7:0]  green;
  logic [7:0]  blue;
  logic        line_end;

  modport source (output valid, level, red, green, blue, line_end, input ready);
  modport sink   (input valid, level, red, green, blue, line_end, output ready);
endinterface

### rtl/sbcr_cfg_if.sv
// ---------------------------------------------------------------------------
// sbcr_cfg_if
// Configuration write channel: register index and data.
// ---------------------------------------------------------------------------
interface sbcr_cfg_if;
  logic        valid;
  logic        ready;
  logic [2:0]  index;
  logic [47:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

### rtl/spectrum_bin_color_ramp.sv
// ---------------------------------------------------------------------------
// spectrum_bin_color_ramp
// Maps a complex spectrum bin to a saturated level and a ramp RGB colour.
// ---------------------------------------------------------------------------
//  Channel  | Dir | Word contents
//  in_ch    | in  | real_part, imag_part (Q15), last_bin
//  out_ch   | out | level, red, green, blue, line_end
//  cfg_ch   | in  | index (0 gain, 1..4 ramp points), data
//
//  One word enters per cycle while the output is not stalled; each word
//  passes 46 register stages, a depth set by the 32-stage square root and
//  the 8-stage colour divider. rst_n is synchronous: it empties the
//  pipeline and reloads the default gain and ramp. A stalled output
//  freezes every stage at once, so nothing is dropped or repeated; cfg_ch
//  is always ready.
// ---------------------------------------------------------------------------
module spectrum_bin_color_ramp
  import sbcr_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  sbcr_in_if.sink     in_ch,
  sbcr_out_if.source  out_ch,
  sbcr_cfg_if.sink    cfg_ch
);

  // stage map: 0 abs, 1 squares, 2 sum, 3..34 sqrt, 35 gain,
  // 36 segment, 37 products, 38..45 divide (output register)
  localparam int LAT = 3 + SQ_STEPS + 3 + DIV_STEPS;

  logic [15:0] gain_r;
  pt_arr_t     pt_r;
  logic [LAT-1:0] vld_r;
  logic        adv;

  // ---- configuration registers ------------------------------------------
  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gain_r   <= GAIN_RST;
      pt_r[0]  <= PT0_RST;
      pt_r[1]  <= PT1_RST;
      pt_r[2]  <= PT2_RST;
      pt_r[3]  <= PT3_RST;
    end else if (cfg_ch.valid) begin
      unique case (cfg_ch.index)
        IDX_GAIN: gain_r  <= cfg_ch.data[15:0];
        IDX_PT0:  pt_r[0] <= cfg_ch.data;
        IDX_PT1:  pt_r[1] <= cfg_ch.data;
        IDX_PT2:  pt_r[2] <= cfg_ch.data;
        IDX_PT3:  pt_r[3] <= cfg_ch.data;
        default: ;  // drop writes past the register list
      endcase
    end
  end

  // ---- flow control: stall everything while the output word waits ------
  assign adv         = !vld_r[LAT-1] || out_ch.ready;
  assign in_ch.ready = adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (adv) begin
      vld_r <= {vld_r[LAT-2:0], in_ch.valid};
    end
  end

  // ---- stage 0: absolute values (most negative value keeps its bits) ----
  logic [31:0] re_abs_r, im_abs_r;
  logic        last0_r;

  always_ff @(posedge clk) begin
    if (adv) begin
      re_abs_r <= in_ch.real_part[31] ? 32'(-in_ch.real_part) : in_ch.real_part;
      im_abs_r <= in_ch.imag_part[31] ? 32'(-in_ch.imag_part) : in_ch.imag_part;
      last0_r  <= in_ch.last_bin;
    end
  end

  // ---- stage 1: squares --------------------------------------------------
  logic [63:0] re_sq_r, im_sq_r;
  logic        last1_r;

  always_ff @(posedge clk) begin
    if (adv) begin
      re_sq_r <= 64'(re_abs_r) * 64'(re_abs_r);
      im_sq_r <= 64'(im_abs_r) * 64'(im_abs_r);
      last1_r <= last0_r;
    end
  end

  // ---- stage 2: power, then one root bit per stage ----------------------
  sq_t sq_r [SQ_STEPS+1];

  always_ff @(posedge clk) begin
    if (adv) begin
      sq_r[0].v    <= re_sq_r + im_sq_r;
      sq_r[0].r    <= '0;
      sq_r[0].last <= last1_r;
    end
  end

  for (genvar k = 0; k < SQ_STEPS; k++) begin : g_sqrt
    localparam logic [63:0] BIT = 64'd1 << (62 - 2 * k);
    logic [63:0] trial;
    sq_t         nxt;

    always_comb begin
      trial    = sq_r[k].r + BIT;
      nxt.last = sq_r[k].last;
      if (sq_r[k].v >= trial) begin
        nxt.v = sq_r[k].v - trial;
        nxt.r = (sq_r[k].r >> 1) + BIT;
      end else begin
        nxt.v = sq_r[k].v;
        nxt.r = sq_r[k].r >> 1;
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        sq_r[k+1] <= nxt;
      end
    end
  end

  // ---- gain and saturation ----------------------------------------------
  logic [47:0] gprod;
  logic [15:0] level_r;
  logic        last_g_r;

  assign gprod = 48'(sq_r[SQ_STEPS].r[31:0]) * 48'(gain_r);

  always_ff @(posedge clk) begin
    if (adv) begin
      level_r  <= (|gprod[47:31]) ? LEVEL_MAX : gprod[30:15];
      last_g_r <= sq_r[SQ_STEPS].last;
    end
  end

  // ---- segment search: advance while the level exceeds the threshold ----
  logic [SEG_W-1:0] cnt, seg;
  logic             run;
  seg_t             seg_r;

  always_comb begin
    cnt = '0;
    run = 1'b1;
    for (int c = 1; c < RAMP_POINTS; c++) begin
      if (run && level_r > pt_thr(pt_r, c)) begin
        cnt = cnt + 1'b1;
      end else begin
        run = 1'b0;
      end
    end
    // clamp to the last segment
    seg = (int'(cnt) > RAMP_POINTS - 2) ? SEG_W'(RAMP_POINTS - 2) : cnt;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      seg_r.level  <= level_r;
      seg_r.lo     <= pt_thr(pt_r, int'(seg));
      seg_r.hi     <= pt_thr(pt_r, int'(seg) + 1);
      seg_r.col_lo <= pt_col(pt_r, int'(seg));
      seg_r.col_hi <= pt_col(pt_r, int'(seg) + 1);
      seg_r.last   <= last_g_r;
    end
  end

  // ---- blend products; ends of the segment bypass the divider -----------
  div_t div_r [DIV_STEPS+1];
  div_t div_nxt0;
  logic [15:0] span, dlt;
  logic        at_lo, at_hi;

  always_comb begin
    span  = seg_r.hi - seg_r.lo;
    dlt   = seg_r.level - seg_r.lo;
    at_lo = seg_r.level <= seg_r.lo;
    at_hi = seg_r.level >= seg_r.hi;
    div_nxt0.byp   = at_lo || at_hi;
    div_nxt0.s     = span;
    div_nxt0.level = seg_r.level;
    div_nxt0.last  = seg_r.last;
    for (int c = 0; c < 3; c++) begin
      logic [7:0]  cl, ch;
      logic [23:0] num;
      cl  = seg_r.col_lo[23 - 8 * c -: 8];
      ch  = seg_r.col_hi[23 - 8 * c -: 8];
      num = 24'(cl) * 24'(span - dlt) + 24'(ch) * 24'(dlt);
      div_nxt0.rem[c] = {1'b0, num[23:8]};
      div_nxt0.nlo[c] = num[7:0];
      div_nxt0.q[c]   = at_lo ? cl : (at_hi ? ch : 8'd0);
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      div_r[0] <= div_nxt0;
    end
  end

  // ---- restoring divide, one quotient bit per stage ---------------------
  for (genvar j = 0; j < DIV_STEPS; j++) begin : g_div
    div_t nxt;

    always_comb begin
      nxt = div_r[j];
      for (int c = 0; c < 3; c++) begin
        logic [16:0] t;
        t = {div_r[j].rem[c][15:0], div_r[j].nlo[c][DIV_STEPS-1-j]};
        if (!div_r[j].byp && t >= {1'b0, div_r[j].s}) begin
          nxt.rem[c]                = t - {1'b0, div_r[j].s};
          nxt.q[c][DIV_STEPS-1-j]   = 1'b1;
        end else begin
          nxt.rem[c] = t;
        end
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        div_r[j+1] <= nxt;
      end
    end
  end

  // ---- result word -------------------------------------------------------
  assign out_ch.valid    = vld_r[LAT-1];
  assign out_ch.level    = div_r[DIV_STEPS].level;
  assign out_ch.red      = div_r[DIV_STEPS].q[0];
  assign out_ch.green    = div_r[DIV_STEPS].q[1];
  assign out_ch.blue     = div_r[DIV_STEPS].q[2];
  assign out_ch.line_end = div_r[DIV_STEPS].last;

endmodule

### rtl/sbcr_checker.sv
// ---------------------------------------------------------------------------
// sbcr_checker
// Port-level checks on handshake and reset behaviour of the colour ramp.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module sbcr_checker (
  input logic clk,
  input logic rst_n,
  input logic in_valid,
  input logic in_ready,
  input logic out_valid,
  input logic out_ready,
  input logic cfg_valid,
  input logic cfg_ready
);

  // hold the result word until taken
  `SBCR_ASSERT(a_out_hold, clk, rst_n, out_valid && !out_ready |=> out_valid)
  // input side advances exactly when the output register can move
  `SBCR_ASSERT(a_in_ready, clk, rst_n, in_ready == (!out_valid || out_ready))
  // configuration writes are never back-pressured
  `SBCR_ASSERT(a_cfg_ready, clk, rst_n, cfg_valid |-> cfg_ready)
  // reset empties the pipeline
  `SBCR_ASSERT_ALWAYS(a_rst_empty, clk, !rst_n |=> !out_valid)

endmodule

bind spectrum_bin_color_ramp sbcr_checker u_sbcr_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_ch.valid),
  .in_ready  (in_ch.ready),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .cfg_valid (cfg_ch.valid),
  .cfg_ready (cfg_ch.ready)
);
